[design/dts_pkg.sv]
// dts_pkg: types and constants shared by the delimited table substitution block.
// No dependencies; dts_front, dts_back and the top level import it.
`timescale 1ns / 1ps

package dts_pkg;

  localparam int BYTE_W          = 8;
  localparam int KEY_MAX         = 3;
  localparam int REPLACEMENT_MAX = 6;
  localparam int KEY_W           = 24;
  localparam int KLEN_W          = 2;
  localparam int REPL_W          = 48;
  localparam int RLEN_W          = 3;
  localparam int ENTRY_IDX_W     = 5;
  localparam int CFG_W           = 6;
  localparam int LA_CNT_W        = $clog2(KEY_MAX + 1);
  localparam int EMIT_CNT_W      = $clog2(REPLACEMENT_MAX + 1);

  // Marker bytes: "|(" opens and "|)" closes a substitution region.
  localparam logic [BYTE_W-1:0] MARK_LEAD  = 8'h7C;
  localparam logic [BYTE_W-1:0] MARK_OPEN  = 8'h28;
  localparam logic [BYTE_W-1:0] MARK_CLOSE = 8'h29;

  typedef struct packed {
    logic                   op;
    logic [BYTE_W-1:0]      data_byte;
    logic                   end_of_stream;
    logic [ENTRY_IDX_W-1:0] entry_index;
    logic [KEY_W-1:0]       key_bytes;
    logic [KLEN_W-1:0]      key_length;
    logic [REPL_W-1:0]      replacement_bytes;
    logic [RLEN_W-1:0]      replacement_length;
  } in_item_t;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              last_of_run;
  } out_item_t;

  typedef enum logic {
    CMD_DATA,
    CMD_WRITE
  } cmd_kind_t;

  // Classified transaction handed from the front end to the back end.
  typedef struct packed {
    cmd_kind_t              kind;
    logic [BYTE_W-1:0]      data_byte;
    logic                   eos;
    logic [ENTRY_IDX_W-1:0] index;
    logic [KEY_W-1:0]       key;
    logic [KLEN_W-1:0]      key_len;
    logic [REPL_W-1:0]      repl;
    logic [RLEN_W-1:0]      repl_len;
  } cmd_t;

  // One word of the replacement memory.
  typedef struct packed {
    logic [KLEN_W-1:0] key_len;
    logic [RLEN_W-1:0] repl_len;
    logic [REPL_W-1:0] repl;
  } repl_word_t;

  typedef logic [KEY_MAX-1:0][BYTE_W-1:0] lookahead_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MATCH,
    ST_SELECT,
    ST_EMIT,
    ST_FLUSH
  } back_state_t;

endpackage

[design/dts_fifo.sv]
// dts_fifo: small synchronous FIFO with push/full and pop/empty handshakes.
// Depends on nothing; DEPTH must be a power of two, at least 2.
`timescale 1ns / 1ps

module dts_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] store_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_push, do_pop;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = store_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      store_r[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

[design/dts_front.sv]
// dts_front: input side; classifies transactions and queues them for the back end.
// Depends on dts_pkg and dts_fifo.
`timescale 1ns / 1ps

module dts_front #(
  parameter int TABLE_DEPTH = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_push,
  input  dts_pkg::in_item_t in_data,
  output logic              in_full,
  input  logic              cmd_pop,
  output dts_pkg::cmd_t     cmd,
  output logic              cmd_empty
);

  import dts_pkg::*;

  cmd_t                cmd_in;
  logic                keep;
  logic                q_full;
  logic [$bits(cmd_t)-1:0] q_rdata;

  // Normalize table writes: overlong keys never match, long replacements saturate.
  always_comb begin
    cmd_in.kind      = in_data.op ? CMD_WRITE : CMD_DATA;
    cmd_in.data_byte = in_data.data_byte;
    cmd_in.eos       = in_data.end_of_stream;
    cmd_in.index     = in_data.entry_index;
    cmd_in.key       = in_data.key_bytes;
    cmd_in.key_len   = in_data.key_length;
    cmd_in.repl      = in_data.replacement_bytes;
    cmd_in.repl_len  = in_data.replacement_length;
    if (int'(in_data.key_length) > KEY_MAX) begin
      cmd_in.key_len = '0;
    end
    if (int'(in_data.replacement_length) > REPLACEMENT_MAX) begin
      cmd_in.repl_len = RLEN_W'(REPLACEMENT_MAX);
    end
  end

  // Writes to slots beyond the table are accepted and dropped here.
  assign keep    = !in_data.op || (int'(in_data.entry_index) < TABLE_DEPTH);
  assign in_full = q_full;
  assign cmd     = cmd_t'(q_rdata);

  dts_fifo #(
    .WIDTH ($bits(cmd_t)),
    .DEPTH (2)
  ) u_cmd_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (in_push && keep),
    .wdata (cmd_in),
    .full  (q_full),
    .pop   (cmd_pop),
    .rdata (q_rdata),
    .empty (cmd_empty)
  );

endmodule

[design/dts_back.sv]
// dts_back: lookahead, substitution table and decision sequencer.
// Depends on dts_pkg; feeds the output FIFO in the top level.
`timescale 1ns / 1ps

module dts_back #(
  parameter int TABLE_DEPTH = 32
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [dts_pkg::CFG_W-1:0] entries_in_use,
  input  logic                      cmd_empty,
  input  dts_pkg::cmd_t             cmd,
  output logic                      cmd_pop,
  input  logic                      out_full,
  output logic                      out_push,
  output dts_pkg::out_item_t        out_item
);

  import dts_pkg::*;

  localparam int TIDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  // Table: keys in flops for the parallel compare, replacements in memory.
  logic [KEY_W-1:0]  key_r  [TABLE_DEPTH];
  logic [KLEN_W-1:0] klen_r [TABLE_DEPTH];
  repl_word_t        mem    [TABLE_DEPTH];
  repl_word_t        rd_r;

  back_state_t             state_r, state_nxt;
  lookahead_t              la_r, la_nxt;
  logic [LA_CNT_W-1:0]     cnt_r, cnt_nxt;
  logic                    subst_r, subst_nxt;
  logic                    eos_r, eos_nxt;
  logic                    use_mem_r, use_mem_nxt;
  logic [2*BYTE_W-1:0]     src_r, src_nxt;
  logic [RLEN_W-1:0]       len_r, len_nxt;
  logic [KLEN_W-1:0]       used_r, used_nxt;
  logic [EMIT_CNT_W-1:0]   emit_idx_r, emit_idx_nxt;
  logic                    held_valid_r, held_valid_nxt;
  logic [BYTE_W-1:0]       held_byte_r, held_byte_nxt;

  logic [TABLE_DEPTH-1:0]  hit_vec, hit_r;
  logic                    marker_vec, marker_r;
  logic [TIDX_W-1:0]       sel_idx;
  logic [TIDX_W-1:0]       wr_idx;
  logic                    tbl_we, mem_re;

  logic [RLEN_W-1:0]       cur_len;
  logic [KLEN_W-1:0]       cur_used;
  logic [BYTE_W-1:0]       cur_byte;
  logic                    last_byte, can_go;
  logic [LA_CNT_W-1:0]     cnt_inc, cnt_after;

  assign wr_idx = TIDX_W'(cmd.index);

  always_ff @(posedge clk) begin
    if (tbl_we) begin
      key_r[wr_idx]  <= cmd.key;
      klen_r[wr_idx] <= cmd.key_len;
    end
  end

  always_ff @(posedge clk) begin
    if (tbl_we) begin
      mem[wr_idx] <= '{key_len: cmd.key_len, repl_len: cmd.repl_len, repl: cmd.repl};
    end
  end

  always_ff @(posedge clk) begin
    if (mem_re) begin
      rd_r <= mem[sel_idx];
    end
  end

  // Per-entry key compare against the lookahead head.
  always_comb begin
    for (int j = 0; j < TABLE_DEPTH; j++) begin
      hit_vec[j] = 1'b0;
      if ((j < int'(entries_in_use)) && (klen_r[j] != '0) &&
          (int'(klen_r[j]) <= int'(cnt_r))) begin
        hit_vec[j] = 1'b1;
        for (int m = 0; m < KEY_MAX; m++) begin
          if ((m < int'(klen_r[j])) && (key_r[j][BYTE_W*m +: BYTE_W] != la_r[m])) begin
            hit_vec[j] = 1'b0;
          end
        end
      end
    end
  end

  assign marker_vec = (cnt_r >= LA_CNT_W'(2)) && (la_r[0] == MARK_LEAD) &&
                      ((la_r[1] == MARK_OPEN) || (la_r[1] == MARK_CLOSE));

  always_ff @(posedge clk) begin
    hit_r    <= hit_vec;
    marker_r <= marker_vec;
  end

  // Lowest matching entry wins.
  always_comb begin
    sel_idx = '0;
    for (int j = TABLE_DEPTH - 1; j >= 0; j--) begin
      if (hit_r[j]) begin
        sel_idx = TIDX_W'(j);
      end
    end
  end

  assign cnt_inc   = cnt_r + 1'b1;
  assign cur_len   = use_mem_r ? rd_r.repl_len : len_r;
  assign cur_used  = use_mem_r ? rd_r.key_len : used_r;
  assign cur_byte  = use_mem_r ? rd_r.repl[BYTE_W*emit_idx_r +: BYTE_W]
                               : src_r[BYTE_W*emit_idx_r[0] +: BYTE_W];
  assign last_byte = (cur_len == '0) || (EMIT_CNT_W'(cur_len) == emit_idx_r + 1'b1);
  assign can_go    = (cur_len == '0) || !held_valid_r || !out_full;
  assign cnt_after = cnt_r - LA_CNT_W'(cur_used);

  always_comb begin
    state_nxt      = state_r;
    la_nxt         = la_r;
    cnt_nxt        = cnt_r;
    subst_nxt      = subst_r;
    eos_nxt        = eos_r;
    use_mem_nxt    = use_mem_r;
    src_nxt        = src_r;
    len_nxt        = len_r;
    used_nxt       = used_r;
    emit_idx_nxt   = emit_idx_r;
    held_valid_nxt = held_valid_r;
    held_byte_nxt  = held_byte_r;
    cmd_pop        = 1'b0;
    tbl_we         = 1'b0;
    mem_re         = 1'b0;
    out_push       = 1'b0;
    out_item       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (!cmd_empty) begin
          cmd_pop = 1'b1;
          if (cmd.kind == CMD_WRITE) begin
            tbl_we = 1'b1;
          end else begin
            for (int i = 0; i < KEY_MAX; i++) begin
              if (cnt_r == LA_CNT_W'(i)) begin
                la_nxt[i] = cmd.data_byte;
              end
            end
            cnt_nxt = cnt_inc;
            eos_nxt = cmd.eos;
            if ((cnt_inc >= LA_CNT_W'(KEY_MAX)) || cmd.eos) begin
              state_nxt = ST_MATCH;
            end
          end
        end
      end
      ST_MATCH: begin
        state_nxt = ST_SELECT;
      end
      ST_SELECT: begin
        emit_idx_nxt = '0;
        state_nxt    = ST_EMIT;
        if (marker_r) begin
          use_mem_nxt = 1'b0;
          src_nxt     = {la_r[1], MARK_LEAD};
          len_nxt     = RLEN_W'(2);
          used_nxt    = KLEN_W'(2);
          subst_nxt   = (la_r[1] == MARK_OPEN);
        end else if (subst_r && (|hit_r)) begin
          use_mem_nxt = 1'b1;
          mem_re      = 1'b1;
        end else begin
          use_mem_nxt = 1'b0;
          src_nxt     = {{BYTE_W{1'b0}}, la_r[0]};
          len_nxt     = RLEN_W'(1);
          used_nxt    = KLEN_W'(1);
        end
      end
      ST_EMIT: begin
        if (can_go) begin
          if (cur_len != '0) begin
            // Keep the newest byte back until we know whether it ends the run.
            if (held_valid_r) begin
              out_push             = 1'b1;
              out_item.out_byte    = held_byte_r;
              out_item.last_of_run = 1'b0;
            end
            held_valid_nxt = 1'b1;
            held_byte_nxt  = cur_byte;
            emit_idx_nxt   = emit_idx_r + 1'b1;
          end
          if (last_byte) begin
            la_nxt  = la_r >> (BYTE_W * int'(cur_used));
            cnt_nxt = cnt_after;
            if (eos_r && (cnt_after != '0)) begin
              state_nxt = ST_MATCH;
            end else begin
              state_nxt = ST_FLUSH;
              if (eos_r) begin
                subst_nxt = 1'b0;
              end
            end
          end
        end
      end
      ST_FLUSH: begin
        if (!held_valid_r) begin
          state_nxt = ST_IDLE;
        end else if (!out_full) begin
          out_push             = 1'b1;
          out_item.out_byte    = held_byte_r;
          out_item.last_of_run = 1'b1;
          held_valid_nxt       = 1'b0;
          state_nxt            = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      cnt_r        <= '0;
      subst_r      <= 1'b0;
      held_valid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cnt_r        <= cnt_nxt;
      subst_r      <= subst_nxt;
      held_valid_r <= held_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    la_r        <= la_nxt;
    eos_r       <= eos_nxt;
    use_mem_r   <= use_mem_nxt;
    src_r       <= src_nxt;
    len_r       <= len_nxt;
    used_r      <= used_nxt;
    emit_idx_r  <= emit_idx_nxt;
    held_byte_r <= held_byte_nxt;
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= LA_CNT_W'(KEY_MAX))
    else $error("lookahead count above key length");

  a_idle_nothing_held: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !held_valid_r)
    else $error("held byte left over at end of transaction");

  a_push_has_room: assert property (@(posedge clk) disable iff (!rst_n)
    out_push |-> !out_full)
    else $error("push into full output queue");

  a_flush_marks_last: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_FLUSH) && out_push) |-> out_item.last_of_run)
    else $error("final byte of a run not flagged");

  a_emit_after_select: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SELECT) |=> (state_r == ST_EMIT))
    else $error("select not followed by emit");

endmodule

[design/delimited_table_substitution.sv]
// delimited_table_substitution: top level of the byte stream translator.
// Depends on dts_pkg, dts_fifo, dts_front and dts_back.
//
// Usage:
//  - Input side is a queue: drive in_data and raise in_push; a transaction is
//    taken on a clock edge with in_push high and in_full low. op=1 loads one
//    table slot, op=0 carries a text byte (end_of_stream flushes lookahead).
//  - Result side is a queue too: while out_empty is low the oldest result is
//    on out_data; raise out_pop to take it. last_of_run flags the final byte
//    caused by one input transaction.
//  - cfg_valid/cfg_ready write entries_in_use; cfg_ready is always high.
//  - Back-end work: a table write or a byte that completes no decision is
//    handled in the idle state alone. Each decision runs a key compare, a
//    priority select with memory read and an emit step per byte (entered even
//    for an empty replacement), and a transaction that reaches any decision
//    ends with a flush step that tags the last byte (spent even when nothing
//    was emitted). The back-end sequencer is the bottleneck.
//  - Reset clears the mode flag, lookahead, entries_in_use and both queues;
//    table slots hold garbage until loaded.
//  - When the receiver stalls, the 4-deep result queue fills, the back end
//    holds mid-run, and the 2-deep command queue then raises in_full.
`timescale 1ns / 1ps

module delimited_table_substitution #(
  parameter int TABLE_DEPTH = 32
) (
  input  logic                      clk,
  input  logic                      rst_n,
  // input transactions
  input  logic                      in_push,
  input  dts_pkg::in_item_t         in_data,
  output logic                      in_full,
  // result transactions
  output logic                      out_empty,
  input  logic                      out_pop,
  output dts_pkg::out_item_t        out_data,
  // configuration write channel
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [dts_pkg::CFG_W-1:0] cfg_data
);

  import dts_pkg::*;

  logic [CFG_W-1:0] entries_in_use_r;
  cmd_t             cmd;
  logic             cmd_empty, cmd_pop;
  logic             res_push, res_full;
  out_item_t        res_item;
  logic [$bits(out_item_t)-1:0] res_rdata;

  // Config writes must arrive only while the block is idle; the block itself does not enforce this (no interlock).
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entries_in_use_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      entries_in_use_r <= cfg_data;
    end
  end

  // Front end: accept, classify, queue.
  dts_front #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_data   (in_data),
    .in_full   (in_full),
    .cmd_pop   (cmd_pop),
    .cmd       (cmd),
    .cmd_empty (cmd_empty)
  );

  // Back end: lookahead window, table search and byte emission.
  dts_back #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .entries_in_use (entries_in_use_r),
    .cmd_empty      (cmd_empty),
    .cmd            (cmd),
    .cmd_pop        (cmd_pop),
    .out_full       (res_full),
    .out_push       (res_push),
    .out_item       (res_item)
  );

  // Result queue decouples the emitter from the downstream consumer.
  dts_fifo #(
    .WIDTH ($bits(out_item_t)),
    .DEPTH (4)
  ) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (res_item),
    .full  (res_full),
    .pop   (out_pop),
    .rdata (res_rdata),
    .empty (out_empty)
  );

  assign out_data = out_item_t'(res_rdata);

endmodule
